// ----- hw/rtl/ddo_pkg.sv -----
// Shared types, register codes and the quarter-wave sine table for the odometry block.
// No dependencies; every other file in hw/rtl imports this package.
package ddo_pkg;

    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_AW = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_IW = $clog2(SINE_TABLE_ENTRIES + 1);

    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] Q30_ONE_HALF = 64'd536870912;

    localparam int GAIN_W  = 24;
    localparam int LIMIT_W = 16;
    localparam int CFG_IW  = 2;

    localparam logic [CFG_IW-1:0] REG_LIN_GAIN     = 2'd0;
    localparam logic [CFG_IW-1:0] REG_TURN_GAIN    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_GLITCH_LIMIT = 2'd2;

    localparam logic [GAIN_W-1:0]  LIN_GAIN_RST     = 24'd3170;
    localparam logic [GAIN_W-1:0]  TURN_GAIN_RST    = 24'd43030;
    localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RST = 16'd150;

    // |delta| <= 65535 on a beat not flagged as a glitch, so sum and difference fit 18 bits
    localparam int SUM_W  = 18;
    localparam int DIST_W = 27;
    localparam int MUL_AW = 27;
    localparam int MUL_BW = 18;
    localparam int PROD_W = MUL_AW + MUL_BW;
    localparam int STEP_W = PROD_W - 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
    } ddo_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [31:0] step_distance;
        logic signed [15:0] step_turn;
        logic               glitch;
    } ddo_out_t;

    typedef struct packed {
        logic              glitch;
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] diff;
    } ddo_op_t;

    typedef logic [SINE_TABLE_ENTRIES-1:0][15:0] sine_rom_t;

    function automatic logic [15:0] quarter_sine(input int unsigned i);
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] s;
        a = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_ENTRIES);
        a2 = (a * a) >> 30;
        term = a;
        s = signed'(a);
        for (int k = 1; k <= 10; k++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) != 0)
                s = s - signed'(term);
            else
                s = s + signed'(term);
        end
        if (s < 0)
            s = 64'sd0;
        v = (unsigned'(s) * 64'd65536 + Q30_ONE_HALF) >> 30;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_TABLE_ENTRIES; i++)
        begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // signed sine of a binary angle, scale 2^16
    function automatic logic signed [16:0] sine_of(input logic [15:0] ang);
        logic [14:0]        p;
        logic [31:0]        scaled;
        logic [SINE_IW-1:0] idx;
        logic [15:0]        v;
        p = {1'b0, ang[13:0]};
        if (ang[14])
            p = 15'd16384 - p;
        scaled = (32'(p) * 32'(SINE_TABLE_ENTRIES)) >> 14;
        idx = scaled[SINE_IW-1:0];
        if (idx >= SINE_IW'(SINE_TABLE_ENTRIES))
            v = 16'hFFFF;
        else
            v = SINE_ROM[idx[SINE_AW-1:0]];
        return ang[15] ? -signed'({1'b0, v}) : signed'({1'b0, v});
    endfunction

endpackage

// ----- hw/rtl/ddo_front.sv -----
// Front end: takes encoder beats, forms count deltas, flags glitches.
// Depends on ddo_pkg.
module ddo_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ddo_pkg::ddo_in_t      in_data,
    input  logic [ddo_pkg::LIMIT_W-1:0] glitch_limit,
    output logic                  push_valid,
    input  logic                  push_ready,
    output ddo_pkg::ddo_op_t      push_data
);
    import ddo_pkg::*;

    logic signed [31:0] last_left_reg;
    logic signed [31:0] last_right_reg;
    logic signed [32:0] dl;
    logic signed [32:0] dr;
    logic [32:0]        mag_l;
    logic [32:0]        mag_r;
    logic signed [33:0] sum;
    logic signed [33:0] diff;
    logic               accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        dl    = 33'(in_data.left_count) - 33'(last_left_reg);
        dr    = 33'(in_data.right_count) - 33'(last_right_reg);
        mag_l = dl[32] ? unsigned'(-dl) : unsigned'(dl);
        mag_r = dr[32] ? unsigned'(-dr) : unsigned'(dr);
        sum   = 34'(dl) + 34'(dr);
        diff  = 34'(dr) - 34'(dl);
        push_data.glitch = (mag_l > 33'(glitch_limit)) || (mag_r > 33'(glitch_limit));
        push_data.sum    = sum[SUM_W-1:0];
        push_data.diff   = diff[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end
        else if (accept)
        begin
            last_left_reg  <= in_data.left_count;
            last_right_reg <= in_data.right_count;
        end
    end

endmodule

// ----- hw/rtl/ddo_queue.sv -----
// Two-entry queue between the front end and the pose engine.
// Depends on ddo_pkg.
module ddo_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  ddo_pkg::ddo_op_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ddo_pkg::ddo_op_t pop_data
);
    import ddo_pkg::*;

    ddo_op_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hw/rtl/ddo_back.sv -----
// Pose engine: one shared 27x18 multiplier sequenced over distance, turn, x and y.
// Holds heading and position; depends on ddo_pkg.
module ddo_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  ddo_pkg::ddo_op_t           pop_data,
    input  logic [ddo_pkg::GAIN_W-1:0] lin_gain,
    input  logic [ddo_pkg::GAIN_W-1:0] turn_gain,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ddo_pkg::ddo_out_t          out_data
);
    import ddo_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MD   = 4'd1;
    localparam logic [3:0] S_MT   = 4'd2;
    localparam logic [3:0] S_HD   = 4'd3;
    localparam logic [3:0] S_CS   = 4'd4;
    localparam logic [3:0] S_MX   = 4'd5;
    localparam logic [3:0] S_SN   = 4'd6;
    localparam logic [3:0] S_MY   = 4'd7;
    localparam logic [3:0] S_RY   = 4'd8;
    localparam logic [3:0] S_UY   = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  diff_reg;
    logic                     glitch_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic [15:0]              turn_reg;
    logic [15:0]              head_reg;
    logic signed [31:0]       x_reg;
    logic signed [31:0]       y_reg;
    logic signed [16:0]       sv_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [STEP_W-1:0] prod_rnd;
    logic                     out_valid_reg;
    ddo_out_t                 out_data_reg;
    logic                     out_free;

    // round to nearest, ties away from zero, drop 16 fraction bits
    function automatic logic signed [STEP_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sh;
        logic [STEP_W-1:0] r;
        mag = v[PROD_W-1] ? unsigned'(-v) : unsigned'(v);
        sh  = (mag + PROD_W'(32768)) >> 16;
        r   = sh[STEP_W-1:0];
        return v[PROD_W-1] ? -signed'(r) : signed'(r);
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [STEP_W-1:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return s[31:0];
    endfunction

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == S_IDLE);
    assign prod_rnd  = rnd16(prod_reg);

    always_comb
    begin
        unique case (state_reg)
            S_MD:
            begin
                mul_a = signed'({3'b000, lin_gain});
                mul_b = sum_reg;
            end
            S_MT:
            begin
                mul_a = signed'({3'b000, turn_gain});
                mul_b = diff_reg;
            end
            default:
            begin
                mul_a = dist_reg;
                mul_b = MUL_BW'(sv_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                    state_next = pop_data.glitch ? S_DONE : S_MD;
            end
            S_MD:    state_next = S_MT;
            S_MT:    state_next = S_HD;
            S_HD:    state_next = S_CS;
            S_CS:    state_next = S_MX;
            S_MX:    state_next = S_SN;
            S_SN:    state_next = S_MY;
            S_MY:    state_next = S_RY;
            S_RY:    state_next = S_UY;
            S_UY:    state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MD || state_reg == S_MT || state_reg == S_MX || state_reg == S_MY)
            prod_reg <= mul_a * mul_b;
        if (state_reg == S_IDLE && pop_valid)
        begin
            sum_reg    <= pop_data.sum;
            diff_reg   <= pop_data.diff;
            glitch_reg <= pop_data.glitch;
            dist_reg   <= '0;
            turn_reg   <= '0;
        end
        if (state_reg == S_MT)
            dist_reg <= DIST_W'(prod_rnd);
        if (state_reg == S_HD)
            turn_reg <= prod_rnd[15:0];
        if (state_reg == S_CS)
            sv_reg <= sine_of(head_reg + 16'd16384);
        if (state_reg == S_SN)
        begin
            sv_reg   <= sine_of(head_reg);
            step_reg <= prod_rnd;
        end
        if (state_reg == S_RY)
            step_reg <= prod_rnd;
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.pos_x         <= x_reg;
            out_data_reg.pos_y         <= y_reg;
            out_data_reg.heading       <= head_reg;
            out_data_reg.step_distance <= 32'(dist_reg);
            out_data_reg.step_turn     <= signed'(turn_reg);
            out_data_reg.glitch        <= glitch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_HD)
                head_reg <= head_reg + prod_rnd[15:0];
            if (state_reg == S_MY)
                x_reg <= sat_add(x_reg, step_reg);
            if (state_reg == S_UY)
                y_reg <= sat_add(y_reg, step_reg);
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- hw/rtl/differential_drive_odometry.sv -----
// Differential-drive wheel odometry. An input beat carries the absolute left and right
// encoder counts and yields one result beat with the new pose and the step taken. The front
// end takes a beat whenever its two-entry queue has room; the pose engine then steps a moving
// sample through its states (its single 27x18 multiplier is used four times, for distance,
// turn, x and y), sends a rejected sample straight to its result state, and takes the next
// beat only when idle. Results sit in an output register; the engine waits only when that
// register is still full. No clearing pass follows reset: the sine table is constant logic.
// Configuration writes (lin_gain, turn_gain, glitch_limit) are taken in any cycle.
module differential_drive_odometry (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ddo_pkg::ddo_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ddo_pkg::ddo_out_t          out_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ddo_pkg::CFG_IW-1:0] cfg_index,
    input  logic [ddo_pkg::GAIN_W-1:0] cfg_data
);
    import ddo_pkg::*;

    logic [GAIN_W-1:0]  lin_gain_reg;
    logic [GAIN_W-1:0]  turn_gain_reg;
    logic [LIMIT_W-1:0] glitch_limit_reg;
    logic               push_valid;
    logic               push_ready;
    ddo_op_t            push_data;
    logic               pop_valid;
    logic               pop_ready;
    ddo_op_t            pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lin_gain_reg     <= LIN_GAIN_RST;
            turn_gain_reg    <= TURN_GAIN_RST;
            glitch_limit_reg <= GLITCH_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LIN_GAIN:     lin_gain_reg     <= cfg_data;
                REG_TURN_GAIN:    turn_gain_reg    <= cfg_data;
                REG_GLITCH_LIMIT: glitch_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          ;
            endcase
        end
    end

    ddo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .glitch_limit (glitch_limit_reg),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_data    (push_data)
    );

    ddo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ddo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .lin_gain  (lin_gain_reg),
        .turn_gain (turn_gain_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- hw/rtl/ddo_checker.sv -----
// Port-level checks for the odometry block, bound to the top level.
// Depends on ddo_pkg and differential_drive_odometry.
module ddo_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input ddo_pkg::ddo_out_t          out_data
);
    import ddo_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // a rejected sample reports no motion
    a_glitch_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.glitch |-> out_data.step_distance == 32'sd0
                                        && out_data.step_turn == 16'sd0)
        else $error("glitch beat with nonzero step");

    // a rejected sample leaves the pose of the previous result unchanged
    a_glitch_pose: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid && out_data.glitch
        |-> out_data.heading == $past(out_data.heading)
            && out_data.pos_x == $past(out_data.pos_x)
            && out_data.pos_y == $past(out_data.pos_y))
        else $error("glitch beat moved the pose");

    // step distance stays within the signed 27-bit product range
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.step_distance[31:26] == 6'h00
                   || out_data.step_distance[31:26] == 6'h3F)
        else $error("step distance out of range");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

// ----- test/differential_drive_odometry_test.sv -----
// Self-checking testbench for differential_drive_odometry: directed rows, then random phases.
// Depends on ddo_pkg for the beat types and register codes; the pose predictor lives here.
`timescale 1ns / 1ps

module differential_drive_odometry_test;
    import ddo_pkg::*;

    localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 45;
    localparam int CRUISE_ITEMS = 120;
    localparam int ROWS         = 24;

    localparam ddo_out_t POSE_AT_ORIGIN   = '0;
    localparam ddo_out_t REJECT_AT_ORIGIN = '{glitch: 1'b1, default: '0};

    typedef enum bit {SAMPLE, REG_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CFG_IW-1:0]  index;
        logic [GAIN_W-1:0]  word;
        logic signed [31:0] left;
        logic signed [31:0] right;
        bit                 typed;
        ddo_out_t           result;
    } script_row_t;

    // reset gains: 3170, 43030, limit 150
    script_row_t script_rows [ROWS] = '{
        '{SAMPLE, REG_LIN_GAIN, '0, 32'sd0, 32'sd0, 1'b1, POSE_AT_ORIGIN},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'sd151, 32'sd0, 1'b1, REJECT_AT_ORIGIN},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'sd301, 32'sd150, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'sd301, 32'sd300, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'sd151, 32'sd300, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'sd1, 32'sd451, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
        '{REG_WRITE, REG_GLITCH_LIMIT, 24'hFF_FFFF, '0, '0, 1'b0, '0},
        '{REG_WRITE, REG_LIN_GAIN, 24'hFF_FFFF, '0, '0, 1'b0, '0},
        '{REG_WRITE, REG_TURN_GAIN, 24'hFF_FFFF, '0, '0, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h7FFF_0000, 32'h8000_FFFF, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8000_FFFF, 32'h7FFF_0000, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8001_FFFE, 32'h7FFF_FFFF, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8000_FFFF, 32'h7FFF_0000, 1'b0, '0},
        '{REG_WRITE, REG_LIN_GAIN, '0, '0, '0, 1'b0, '0},
        '{REG_WRITE, REG_TURN_GAIN, '0, '0, '0, 1'b0, '0},
        '{REG_WRITE, REG_GLITCH_LIMIT, '0, '0, '0, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8000_FFFF, 32'h7FFF_0000, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8001_0000, 32'h7FFF_0000, 1'b0, '0},
        '{REG_WRITE, REG_UNUSED, 24'hFF_FFFF, '0, '0, 1'b0, '0},
        '{SAMPLE, REG_LIN_GAIN, '0, 32'h8001_0000, 32'h7FFF_0000, 1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    ddo_in_t              in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    ddo_out_t             out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IW-1:0]    cfg_index = '0;
    logic [GAIN_W-1:0]    cfg_data = '0;

    // predictor state
    logic [15:0]          quarter_wave [SINE_TABLE_ENTRIES];
    logic [GAIN_W-1:0]    odo_lin_gain;
    logic [GAIN_W-1:0]    odo_turn_gain;
    logic [LIMIT_W-1:0]   odo_limit;
    logic signed [31:0]   odo_left;
    logic signed [31:0]   odo_right;
    logic signed [31:0]   odo_x;
    logic signed [31:0]   odo_y;
    logic [15:0]          odo_heading;

    ddo_out_t             pose_queue [$];
    ddo_out_t             oldest_pose;
    logic signed [31:0]   sent_left = '0;
    logic signed [31:0]   sent_right = '0;
    int                   gap_pct = 0;
    int                   stall_pct = 0;
    int                   stall_left = 0;
    int                   fail_count = 0;
    int                   cycle_count = 0;

    differential_drive_odometry DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Q30 Taylor series of sin(pi/2 * i / N), rounded to unsigned 0.16
    function automatic logic [15:0] taylor_quarter_sine(input int unsigned i);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned div;
        longint unsigned rounded;
        longint          acc;
        int              k;
        ang = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_ENTRIES);
        ang_sq = (ang * ang) >> 30;
        term = ang;
        acc = signed'(ang);
        for (k = 1; k <= 10; k++)
        begin
            div = 64'(4 * k * k + 2 * k);
            term = ((term * ang_sq) >> 30) / div;
            acc = (k % 2 == 1) ? acc - signed'(term) : acc + signed'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (unsigned'(acc) * 64'd65536 + Q30_ONE_HALF) >> 30;
        return (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
    endfunction

    function automatic longint signed_sine(input logic [15:0] ang);
        logic [14:0] off;
        int          idx;
        longint      mag;
        off = {1'b0, ang[13:0]};
        if (ang[14])
            off = 15'd16384 - off;
        idx = (int'(off) * SINE_TABLE_ENTRIES) >> 14;
        if (idx >= SINE_TABLE_ENTRIES)
            mag = 65535;
        else
            mag = longint'(quarter_wave[idx]);
        return ang[15] ? -mag : mag;
    endfunction

    // shift right 16, round to nearest, ties away from zero
    function automatic longint round_off16(input longint v);
        longint unsigned mag;
        mag = (v < 0) ? unsigned'(-v) : unsigned'(v);
        mag = (mag + 64'd32768) >> 16;
        return (v < 0) ? -signed'(mag) : signed'(mag);
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] base,
                                                     input longint delta);
        longint total;
        total = longint'(base) + delta;
        if (total > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (total < -64'sd2147483648)
            return 32'h8000_0000;
        return total[31:0];
    endfunction

    function automatic ddo_out_t advance_pose(input ddo_in_t counts);
        ddo_out_t pose;
        longint   d_left;
        longint   d_right;
        longint   travel;
        longint   turn;
        longint   lim;
        logic     rejected;
        d_left = longint'(counts.left_count) - longint'(odo_left);
        d_right = longint'(counts.right_count) - longint'(odo_right);
        lim = longint'(odo_limit);
        rejected = (d_left > lim) || (-d_left > lim) || (d_right > lim) || (-d_right > lim);
        odo_left = counts.left_count;
        odo_right = counts.right_count;
        travel = 0;
        turn = 0;
        if (!rejected)
        begin
            travel = round_off16(longint'(odo_lin_gain) * (d_left + d_right));
            turn = round_off16(longint'(odo_turn_gain) * (d_right - d_left));
            odo_heading = odo_heading + turn[15:0];
            odo_x = clamp_add(odo_x, round_off16(travel * signed_sine(odo_heading + 16'h4000)));
            odo_y = clamp_add(odo_y, round_off16(travel * signed_sine(odo_heading)));
        end
        pose.pos_x = odo_x;
        pose.pos_y = odo_y;
        pose.heading = odo_heading;
        pose.step_distance = travel[31:0];
        pose.step_turn = turn[15:0];
        pose.glitch = rejected;
        return pose;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            5: return GAIN_W'($urandom());
            default: return GAIN_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // entry and exit at a falling edge
    task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [GAIN_W-1:0] word);
        in_valid = 1'b0;
        while (pose_queue.size() != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = word;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LIN_GAIN:     odo_lin_gain = word;
            REG_TURN_GAIN:    odo_turn_gain = word;
            REG_GLITCH_LIMIT: odo_limit = word[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_counts(input logic signed [31:0] left, input logic signed [31:0] right,
                               input bit typed, input ddo_out_t typed_pose);
        ddo_in_t  counts;
        ddo_out_t predicted;
        counts.left_count = left;
        counts.right_count = right;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = counts;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = advance_pose(counts);
        pose_queue = {pose_queue, (typed ? typed_pose : predicted)};
        sent_left = left;
        sent_right = right;
        @(negedge clk);
    endtask

    task automatic compare_field(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left == 0 && stall_pct > 0 && $urandom_range(99) < stall_pct)
            stall_left = $urandom_range(1, 7);
        out_ready = (stall_left == 0);
        if (stall_left > 0)
            stall_left--;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_queue.size() == 0)
            begin
                $error("result beat with no pending expectation");
                fail_count++;
            end
            else
            begin
                oldest_pose = pose_queue.pop_front();
                compare_field("pos_x", oldest_pose.pos_x, out_data.pos_x);
                compare_field("pos_y", oldest_pose.pos_y, out_data.pos_y);
                compare_field("heading", oldest_pose.heading, out_data.heading);
                compare_field("step_distance", oldest_pose.step_distance,
                              out_data.step_distance);
                compare_field("step_turn", oldest_pose.step_turn, out_data.step_turn);
                compare_field("glitch", oldest_pose.glitch, out_data.glitch);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int                 phase;
        int                 beats;
        int                 span;
        int                 dir;
        int                 pick;
        int                 excess;
        int                 dl;
        int                 dr;
        bit                 flat_out;
        bit                 cruising;
        logic signed [31:0] next_left;
        logic signed [31:0] next_right;

        for (int i = 0; i < SINE_TABLE_ENTRIES; i++)
            quarter_wave[i] = taylor_quarter_sine(i);
        odo_lin_gain = 24'd3170;
        odo_turn_gain = 24'd43030;
        odo_limit = 16'd150;
        odo_left = '0;
        odo_right = '0;
        odo_x = '0;
        odo_y = '0;
        odo_heading = '0;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        gap_pct = 20;
        stall_pct = 8;
        foreach (script_rows[n])
        begin
            if (script_rows[n].kind == REG_WRITE)
                write_register(script_rows[n].index, script_rows[n].word);
            else
                send_counts(script_rows[n].left, script_rows[n].right,
                            script_rows[n].typed, script_rows[n].result);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            flat_out = (phase >= PHASES - 2);
            cruising = (phase == 3 || phase == 8);
            gap_pct = flat_out ? 0 : 25 * $urandom_range(2);
            stall_pct = flat_out ? 0 : 10 * $urandom_range(2);
            dir = (phase == 3) ? 1 : -1;
            if (cruising)
            begin
                span = 65535;
                write_register(REG_LIN_GAIN, '1);
                write_register(REG_TURN_GAIN, GAIN_W'($urandom()));
                write_register(REG_GLITCH_LIMIT, {8'($urandom()), 16'hFFFF});
                beats = CRUISE_ITEMS;
            end
            else
            begin
                case ($urandom_range(3))
                    0: span = 0;
                    1: span = 65535;
                    2: span = $urandom_range(1, 300);
                    default: span = $urandom_range(0, 65535);
                endcase
                write_register(REG_LIN_GAIN, pick_gain());
                write_register(REG_TURN_GAIN, pick_gain());
                write_register(REG_GLITCH_LIMIT, {8'($urandom()), 16'(span)});
                if ($urandom_range(3) == 0)
                    write_register(REG_UNUSED, GAIN_W'($urandom()));
                beats = PHASE_ITEMS;
            end
            repeat (beats)
            begin
                pick = $urandom_range(99);
                if (cruising)
                begin
                    // long straight runs push x or y into saturation
                    dl = dir * 65535;
                    dr = dl;
                    if (pick < 10)
                    begin
                        dl = int'($urandom_range(0, 4000)) - 2000;
                        dr = -dl;
                    end
                    next_left = sent_left + dl;
                    next_right = sent_right + dr;
                end
                else if (pick < 80)
                begin
                    dl = int'($urandom_range(0, 2 * span)) - span;
                    dr = int'($urandom_range(0, 2 * span)) - span;
                    if (pick < 8)
                        dl = span;
                    else if (pick < 16)
                        dr = -span;
                    next_left = sent_left + dl;
                    next_right = sent_right + dr;
                end
                else if (pick < 92)
                begin
                    excess = span + 1 + $urandom_range(0, 2000);
                    dl = int'($urandom_range(0, 2 * span)) - span;
                    dr = $urandom_range(1) ? excess : -excess;
                    if ($urandom_range(1))
                    begin
                        next_left = sent_left + dr;
                        next_right = sent_right + dl;
                    end
                    else
                    begin
                        next_left = sent_left + dl;
                        next_right = sent_right + dr;
                    end
                end
                else
                begin
                    next_left = $urandom();
                    next_right = $urandom();
                end
                send_counts(next_left, next_right, 1'b0, '0);
            end
        end

        in_valid = 1'b0;
        while (pose_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_front.sv
hw/rtl/ddo_queue.sv
hw/rtl/ddo_back.sv
hw/rtl/differential_drive_odometry.sv
hw/rtl/ddo_checker.sv
test/differential_drive_odometry_test.sv
